// ===== src/rawenc_pkg.sv =====
// Shared types and constants of the radix ASCII word encoder.
`default_nettype none

package rawenc_pkg;

   localparam int WORD_W     = 32;
   localparam int DIGIT_W    = 7;
   localparam int QUOT_W     = 26;
   localparam int NUM_DIGITS = 5;
   localparam int IDX_W      = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIGIT_W-1:0] RADIX_85   = 7'd85;
   localparam logic [DIGIT_W-1:0] RADIX_95   = 7'd95;
   localparam logic [DIGIT_W-1:0] ASCII_BASE = 7'd32;

   // floor(2^38 / base); the estimate they give is never more than one below the quotient.
   localparam int                RECIP_SHIFT = 38;
   localparam logic [WORD_W-1:0] RECIP_85    = 32'd3233857728;
   localparam logic [WORD_W-1:0] RECIP_95    = 32'd2893451652;

   localparam logic [CSR_ADDR_W-3:0] REG_RADIX = 1'd0;

   localparam logic [IDX_W-1:0] IDX_FIRST = 3'd0;
   localparam logic [IDX_W-1:0] IDX_LAST  = 3'd4;

   typedef struct packed {
      logic               done;
      logic [QUOT_W-1:0]  quot;
      logic [DIGIT_W-1:0] rem;
   } div_res_type;

endpackage

`default_nettype wire

// ===== src/rawenc_if.sv =====
// Handshake channels for input bytes and output characters.
`default_nettype none

interface rawenc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rawenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       group_last;

   modport source (output valid, output out_char, output group_last, input ready);
   modport sink (input valid, input out_char, input group_last, output ready);
endinterface

`default_nettype wire

// ===== src/rawenc_divu.sv =====
// Divide-by-radix unit: a registered reciprocal multiply, then a registered correction step.
`default_nettype none

module rawenc_divu
   import rawenc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WORD_W-1:0] dividend,
   input  wire logic              base_95,
   output div_res_type            result
);

   logic [2*WORD_W-1:0] prod_ff;
   logic [WORD_W-1:0]   dvd_ff;
   logic                pend_ff;
   logic                done_ff;
   logic [QUOT_W-1:0]   quot_ff;
   logic [DIGIT_W-1:0]  rem_ff;

   logic [WORD_W-1:0]   recip;
   logic [DIGIT_W-1:0]  base_d;
   logic [QUOT_W-1:0]   q_est;
   logic [WORD_W-1:0]   back_mul;
   logic [WORD_W-1:0]   rem_raw;
   logic [7:0]          rem_low;
   logic [QUOT_W-1:0]   quot_in;
   logic [DIGIT_W-1:0]  rem_in;

   assign recip  = base_95 ? RECIP_95 : RECIP_85;
   assign base_d = base_95 ? RADIX_95 : RADIX_85;

   always_comb begin
      q_est    = prod_ff[RECIP_SHIFT +: QUOT_W];
      back_mul = {6'd0, q_est} * {25'd0, base_d};
      rem_raw  = dvd_ff - back_mul;
      // The estimate leaves a remainder below twice the base.
      rem_low  = rem_raw[7:0];
      if (rem_low >= {1'b0, base_d}) begin
         rem_in  = DIGIT_W'(rem_low - {1'b0, base_d});
         quot_in = q_est + 1'b1;
      end else begin
         rem_in  = rem_low[DIGIT_W-1:0];
         quot_in = q_est;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pend_ff <= start;
         done_ff <= pend_ff;
      end
      if (start) begin
         prod_ff <= {32'd0, dividend} * {32'd0, recip};
         dvd_ff  <= dividend;
      end
      if (pend_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign result = '{done: done_ff, quot: quot_ff, rem: rem_ff};

endmodule

`default_nettype wire

// ===== src/rawenc_csr.sv =====
// APB register block holding the radix setting.
`default_nettype none

module rawenc_csr
   import rawenc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic                       base_95
);

   logic [DIGIT_W-1:0] radix_ff;
   logic               hit_radix;

   assign hit_radix = (paddr[CSR_ADDR_W-1:2] == REG_RADIX);
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_85;
      end else if (psel && penable && pwrite && pready && hit_radix) begin
         radix_ff <= pwdata[DIGIT_W-1:0];
      end
   end

   assign prdata  = hit_radix ? {25'd0, radix_ff} : '0;
   // Any value other than 95 runs in base 85.
   assign base_95 = (radix_ff == RADIX_95);

endmodule

`default_nettype wire

// ===== src/radix_ascii_word_encoder.sv =====
// Top level of the radix ASCII word encoder: byte packing, digit sequencer, output stage.
//
// Bytes enter on req_chan, one per transfer, and are packed big-endian into a 32-bit
// group. A group closes on its fourth byte or on a byte marked last_byte; missing low
// bytes are zero. The group is then split into five digits of radix 85 or 95 (register
// radix at APB byte address 0; any value other than 95 means 85) and five characters,
// space plus digit, leave on rsp_chan most significant first, group_last on the fifth.
// A byte that does not close a group is only packed. A closing byte starts the shared
// divide unit, which yields the digits one after another, each by a reciprocal multiply
// and then one correction, each starting when the one before is done. Once all five are
// in, the characters follow one per cycle while rsp_chan.ready is high. req_chan.ready is
// low from the closing transfer until the fifth character has been taken. When
// rsp_chan.ready is low, the current character is held and the block waits. Synchronous
// reset clears the partial group and sets the radix to 85.
`default_nettype none

module radix_ascii_word_encoder
   import rawenc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   rawenc_req_if.sink                 req_chan,
   rawenc_rsp_if.source               rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   typedef enum logic [1:0] {ST_FILL, ST_DIV, ST_SEND} state_type;

   state_type          state_ff, state_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [1:0]         count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DIGIT_W-1:0] digit_ff [NUM_DIGITS];

   logic               base_95;
   logic               req_xfer;
   logic               rsp_xfer;
   logic               close_group;
   logic [WORD_W-1:0]  byte_placed;
   logic [WORD_W-1:0]  packed_word;
   logic               div_start;
   logic [WORD_W-1:0]  div_dividend;
   div_res_type        div_res;

   rawenc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .base_95 (base_95)
   );

   rawenc_divu u_divu (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .base_95  (base_95),
      .result   (div_res)
   );

   assign req_chan.ready = (state_ff == ST_FILL);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;

   // The first byte of a group lands in bits 31..24.
   assign byte_placed = {24'd0, req_chan.data_byte} << {~count_ff, 3'b000};
   assign packed_word = word_ff | byte_placed;
   assign close_group = (count_ff == 2'd3) || req_chan.last_byte;

   assign div_start    = (req_xfer && close_group)
                      || ((state_ff == ST_DIV) && div_res.done && (idx_ff != IDX_FIRST));
   assign div_dividend = (state_ff == ST_FILL) ? packed_word : {6'd0, div_res.quot};

   always_comb begin
      state_in = state_ff;
      word_in  = word_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_xfer) begin
               if (close_group) begin
                  state_in = ST_DIV;
                  word_in  = '0;
                  count_in = 2'd0;
                  idx_in   = IDX_LAST;
               end else begin
                  word_in  = packed_word;
                  count_in = count_ff + 2'd1;
               end
            end
         end
         ST_DIV: begin
            // Remainders come out least significant first and fill the digits from the end.
            if (div_res.done) begin
               if (idx_ff == IDX_FIRST) begin
                  state_in = ST_SEND;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         ST_SEND: begin
            if (rsp_xfer) begin
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_FILL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         word_ff  <= '0;
         count_ff <= 2'd0;
         idx_ff   <= IDX_FIRST;
      end else begin
         state_ff <= state_in;
         word_ff  <= word_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
      if ((state_ff == ST_DIV) && div_res.done) begin
         digit_ff[idx_ff] <= div_res.rem + ASCII_BASE;
      end
   end

   assign rsp_chan.valid      = (state_ff == ST_SEND);
   assign rsp_chan.out_char   = digit_ff[idx_ff];
   assign rsp_chan.group_last = (idx_ff == IDX_LAST);

endmodule

`default_nettype wire

// ===== dv/radix_ascii_word_encoder_tb.sv =====
// Testbench for the radix ASCII word encoder: random and directed byte streams, checked per character.
`timescale 1ns / 1ps

module radix_ascii_word_encoder_tb;
   import rawenc_pkg::*;

   localparam int CLK_HALF    = 6;
   localparam int RESET_LEN   = 6;
   localparam int SETTLE      = 24;
   localparam int HOLD_LEN    = 220;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 26;

   // Word index 1 lies past the only register.
   localparam logic [CSR_ADDR_W-3:0] REG_SPARE = 1'd1;

   typedef struct {
      bit [DIGIT_W-1:0] ch;
      bit               gl;
   } enc_char_type;

   // Tracks the group being packed and the characters it will produce.
   class char_tracker;
      bit [DIGIT_W-1:0] radix_reg;
      bit [WORD_W-1:0]  word_acc;
      bit [1:0]         fill;
      enc_char_type     pending_chars[$];
      int               errors;

      function new();
         radix_reg = RADIX_85;
         word_acc  = '0;
         fill      = '0;
         errors    = 0;
      endfunction

      function void set_radix(bit [CSR_DATA_W-1:0] value);
         radix_reg = value[DIGIT_W-1:0];
      endfunction

      function void note_byte(bit [7:0] b, bit l);
         int unsigned      base;
         bit [WORD_W-1:0]  w;
         bit [DIGIT_W-1:0] digit[NUM_DIGITS];
         enc_char_type     c;
         int               k;
         word_acc = word_acc | (WORD_W'(b) << (24 - 8 * fill));
         if (fill != 2'd3 && !l) begin
            fill = fill + 2'd1;
            return;
         end
         base = (radix_reg == RADIX_95) ? 95 : 85;
         w = word_acc;
         for (k = NUM_DIGITS - 1; k >= 0; k--) begin
            digit[k] = DIGIT_W'(w % base);
            w = w / base;
         end
         for (k = 0; k < NUM_DIGITS; k++) begin
            c.ch = ASCII_BASE + digit[k];
            c.gl = (k == NUM_DIGITS - 1);
            pending_chars.push_back(c);
         end
         word_acc = '0;
         fill     = '0;
      endfunction

      function void check_char(bit [DIGIT_W-1:0] ch, bit gl);
         enc_char_type c;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character %0d group_last %0d", $time, ch, gl);
            errors++;
            return;
         end
         c = pending_chars.pop_front();
         if (ch !== c.ch) begin
            $display("%0t: out_char mismatch, expected %0d, actual %0d", $time, c.ch, ch);
            errors++;
         end
         if (gl !== c.gl) begin
            $display("%0t: group_last mismatch, expected %0d, actual %0d", $time, c.gl, gl);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_chars.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   rawenc_req_if req_chan();
   rawenc_rsp_if rsp_chan();

   char_tracker sb = new();
   bit          hold_req;
   int          cycles;

   radix_ascii_word_encoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[radix_ascii_word_encoder] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_char(rsp_chan.out_char, rsp_chan.group_last);
      end
   end

   // Receiver: random ready pattern, with one long hold-off on request.
   initial begin
      int r;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               rsp_chan.ready <= 1'b1;
               repeat ($urandom_range(20, 60)) @(negedge clock);
            end else if (r < 65) begin
               rsp_chan.ready <= 1'b1;
               repeat ($urandom_range(1, 6)) @(negedge clock);
            end else if (r < 92) begin
               rsp_chan.ready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(negedge clock);
            end else begin
               rsp_chan.ready <= 1'b0;
               repeat ($urandom_range(15, 50)) @(negedge clock);
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] b, input logic l, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last_byte <= l;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_byte(b, l);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr[CSR_ADDR_W-1:2] == REG_RADIX) sb.set_radix(data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_read_radix();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {REG_RADIX, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[DIGIT_W-1:0] !== sb.radix_reg) begin
         $display("%0t: radix readback mismatch, expected %0d, actual %0d",
                  $time, sb.radix_reg, prdata[DIGIT_W-1:0]);
         sb.errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 8'h00;
      if (r < 20) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_gap(bit dense);
      int r;
      if (dense) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      logic [6:0]            radix_set[NUM_PHASES];
      int                    last_pct[NUM_PHASES];
      logic [CSR_DATA_W-1:0] wval;
      bit                    dense;
      int                    ph;
      int                    i;

      radix_set = '{7'd85, 7'd95, 7'd0, 7'd127, 7'd95, 7'd86, 7'd94, 7'd85, 7'd95, 7'd0};
      last_pct  = '{0, 10, 25, 50, 100, 15, 0, 35, 5, 70};

      reset              = 1'b1;
      hold_req           = 1'b0;
      cycles             = 0;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;

      repeat (RESET_LEN) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset radix: zero word, full word, short groups.
      csr_read_radix();
      repeat (4) send_byte(8'h00, 1'b0, 0);
      repeat (4) send_byte(8'hFF, 1'b0, 0);
      send_byte(8'hFF, 1'b1, 0);
      send_byte(8'h12, 1'b0, 1);
      send_byte(8'h34, 1'b1, 0);
      send_byte(8'h80, 1'b0, 0);
      send_byte(8'h00, 1'b0, 2);
      send_byte(8'h7F, 1'b1, 0);
      wait_for_drain();

      csr_write({REG_RADIX, 2'b00}, 32'(RADIX_95));
      csr_read_radix();
      repeat (4) send_byte(8'hFF, 1'b0, 0);
      send_byte(8'h00, 1'b1, 0);

      // Radix changes while a group is half packed; the completed group uses the new one.
      send_byte(8'h11, 1'b0, 0);
      send_byte(8'h22, 1'b0, 0);
      wait_for_drain();
      csr_write({REG_RADIX, 2'b00}, 32'h0000_0155);
      send_byte(8'h33, 1'b0, 0);
      send_byte(8'h44, 1'b0, 0);
      wait_for_drain();

      // Upper data bits are dropped, and a write past the register is ignored.
      csr_write({REG_RADIX, 2'b00}, 32'hFFFF_FF5F);
      csr_write({REG_SPARE, 2'b00}, 32'(RADIX_85));
      csr_read_radix();
      send_byte(8'hA5, 1'b1, 0);
      wait_for_drain();

      csr_write({REG_RADIX, 2'b00}, 32'd0);
      send_byte(8'hFF, 1'b1, 0);
      wait_for_drain();
      csr_write({REG_RADIX, 2'b00}, 32'd127);
      send_byte(8'hFE, 1'b0, 0);
      send_byte(8'hDC, 1'b0, 0);
      send_byte(8'hBA, 1'b1, 0);
      wait_for_drain();

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wval = $urandom();
         wval[6:0] = (ph == NUM_PHASES - 1) ? 7'($urandom_range(0, 127)) : radix_set[ph];
         csr_write({REG_RADIX, 2'b00}, wval);
         if (ph % 3 == 2) csr_read_radix();
         dense = (ph % 4 == 1);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            send_byte(pick_byte(), ($urandom_range(0, 99) < last_pct[ph]), pick_gap(dense));
            // The sender stops mid-phase until every pending character is out.
            if (ph == 5 && i == PHASE_ITEMS / 2) wait_for_drain();
         end
         if (ph == 3) begin
            // Receiver holds off while bytes keep coming, so the input stalls.
            hold_req = 1'b1;
            for (i = 0; i < 20; i++) begin
               send_byte(pick_byte(), ($urandom_range(0, 99) < 20), 0);
            end
         end
         wait_for_drain();
      end

      repeat (30) @(negedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("[radix_ascii_word_encoder] OK");
      end else begin
         $display("[radix_ascii_word_encoder] ERROR");
      end
      $finish;
   end

endmodule
